// File: sv/hhlp_pkg.sv
package hhlp_pkg;

   localparam int OFFSET_BITS_DEFAULT = 16;
   localparam int NAME_COUNT          = 6;

   // Known key names, right-justified; char i of a name of length L sits
   // at bits [(L-1-i)*8 +: 8].
   localparam logic [127:0] NAME_TEXT [NAME_COUNT] = '{
      "content-length", "content-type", "date", "connection", "keep-alive", "host"
   };
   localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
      4'd14, 4'd12, 4'd4, 4'd10, 4'd10, 4'd4
   };

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   typedef enum logic [2:0] {
      KIND_CONTENT_LENGTH = 3'd0,
      KIND_CONTENT_TYPE   = 3'd1,
      KIND_DATE           = 3'd2,
      KIND_CONNECTION     = 3'd3,
      KIND_KEEP_ALIVE     = 3'd4,
      KIND_HOST           = 3'd5,
      KIND_OTHER          = 3'd6,
      KIND_END            = 3'd7
   } line_kind_type;

   typedef enum logic [1:0] {
      PHASE_KEY   = 2'd0,
      PHASE_BLANK = 2'd1,
      PHASE_VALUE = 2'd2
   } phase_type;

   typedef struct packed {
      line_kind_type line_kind;
      logic [15:0]   key_start;
      logic [15:0]   key_length;
      logic [15:0]   value_start;
      logic [15:0]   value_length;
      logic [31:0]   length_value;
      logic          final_record;
   } rec_type;

endpackage

// File: sv/hhlp_name_match.sv
// Per-byte key compare: flags the names that the current key byte rules out.
module hhlp_name_match #(
   parameter int OFFSET_BITS = hhlp_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic [OFFSET_BITS-1:0]          key_index,
   input  logic [7:0]                      key_byte,
   output logic [hhlp_pkg::NAME_COUNT-1:0] name_miss
);

   logic [7:0] lower_byte;

   always_comb begin
      if (key_byte >= hhlp_pkg::CHAR_UC_A && key_byte <= hhlp_pkg::CHAR_UC_Z) begin
         lower_byte = key_byte | hhlp_pkg::CASE_BIT;
      end else begin
         lower_byte = key_byte;
      end
   end

   for (genvar n = 0; n < hhlp_pkg::NAME_COUNT; n++) begin : g_name
      logic [3:0] char_pos;
      logic [7:0] name_char;
      logic       in_range;

      assign in_range  = key_index < OFFSET_BITS'(hhlp_pkg::NAME_LEN[n]);
      assign char_pos  = hhlp_pkg::NAME_LEN[n] - 4'd1 - key_index[3:0];
      assign name_char = hhlp_pkg::NAME_TEXT[n][{char_pos, 3'b000} +: 8];
      assign name_miss[n] = in_range && (lower_byte != name_char);
   end

endmodule

// File: sv/hhlp_parse_core.sv
// Line parser state and record build, one byte per cycle while byte_fire is high.
module hhlp_parse_core #(
   parameter int OFFSET_BITS = hhlp_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_fire,
   input  logic [7:0]        data_byte,
   input  logic              last_byte,
   output logic              rec_valid,
   output hhlp_pkg::rec_type rec
);

   localparam int NC = hhlp_pkg::NAME_COUNT;

   hhlp_pkg::phase_type    phase_ff, phase_in;
   logic [OFFSET_BITS-1:0] byte_offset_ff, byte_offset_in;
   logic [OFFSET_BITS-1:0] line_start_ff, line_start_in;
   logic [OFFSET_BITS-1:0] colon_offset_ff, colon_offset_in;
   logic [OFFSET_BITS-1:0] value_offset_ff, value_offset_in;
   logic [NC-1:0]          match_flags_ff, match_flags_in;
   logic                   prior_cr_ff, prior_cr_in;
   logic [31:0]            digit_acc_ff, digit_acc_in;
   logic                   digits_on_ff, digits_on_in;
   logic                   headers_done_ff, headers_done_in;

   logic [OFFSET_BITS-1:0] ofs_next, ofs_prev, eol, key_index;
   logic [OFFSET_BITS-1:0] klen, vstart, vlen;
   logic [NC-1:0]          name_miss;
   logic                   crlf, is_digit;
   logic [31:0]            digit_next;
   hhlp_pkg::line_kind_type kind;

   assign ofs_next  = byte_offset_ff + OFFSET_BITS'(1);
   assign ofs_prev  = byte_offset_ff - OFFSET_BITS'(1);
   assign key_index = byte_offset_ff - line_start_ff;
   assign crlf      = prior_cr_ff && (data_byte == hhlp_pkg::CHAR_LF);
   assign eol       = crlf ? ofs_prev : byte_offset_ff;

   hhlp_name_match #(.OFFSET_BITS(OFFSET_BITS)) u_name_match (
      .key_index (key_index),
      .key_byte  (data_byte),
      .name_miss (name_miss)
   );

   assign is_digit   = data_byte >= hhlp_pkg::CHAR_ZERO && data_byte <= hhlp_pkg::CHAR_NINE;
   assign digit_next = (digit_acc_ff << 3) + (digit_acc_ff << 1)
                     + {28'd0, data_byte[3:0]};

   // line geometry for the record
   always_comb begin
      if (phase_ff == hhlp_pkg::PHASE_KEY) begin
         klen   = eol - line_start_ff;
         vstart = eol;
         vlen   = '0;
      end else if (phase_ff == hhlp_pkg::PHASE_VALUE) begin
         klen   = colon_offset_ff - line_start_ff;
         vstart = value_offset_ff;
         vlen   = eol - value_offset_ff;
      end else begin
         klen   = colon_offset_ff - line_start_ff;
         vstart = eol;
         vlen   = '0;
      end
   end

   // first surviving name of matching length wins
   always_comb begin
      kind = hhlp_pkg::KIND_OTHER;
      for (int n = NC - 1; n >= 0; n--) begin
         if (match_flags_ff[n] && klen == OFFSET_BITS'(hhlp_pkg::NAME_LEN[n])) begin
            kind = hhlp_pkg::line_kind_type'(3'(n));
         end
      end
   end

   always_comb begin
      logic [31:0] ls_w, ks_w, vs_w, vl_w, nx_w;
      ls_w = 32'(line_start_ff);
      ks_w = 32'(klen);
      vs_w = 32'(vstart);
      vl_w = 32'(vlen);
      nx_w = 32'(ofs_next);

      phase_in        = phase_ff;
      byte_offset_in  = byte_offset_ff;
      line_start_in   = line_start_ff;
      colon_offset_in = colon_offset_ff;
      value_offset_in = value_offset_ff;
      match_flags_in  = match_flags_ff;
      prior_cr_in     = prior_cr_ff;
      digit_acc_in    = digit_acc_ff;
      digits_on_in    = digits_on_ff;
      headers_done_in = headers_done_ff;
      rec_valid       = 1'b0;

      rec.line_kind    = kind;
      rec.key_start    = ls_w[15:0];
      rec.key_length   = ks_w[15:0];
      rec.value_start  = vs_w[15:0];
      rec.value_length = vl_w[15:0];
      rec.length_value = (phase_ff == hhlp_pkg::PHASE_KEY) ? 32'd0 : digit_acc_ff;
      rec.final_record = last_byte;

      if (byte_fire) begin
         byte_offset_in = ofs_next;
         if (headers_done_ff) begin
            // trailing payload bytes: just count
         end else if (crlf) begin
            rec_valid = 1'b1;
            if (ofs_prev == line_start_ff) begin
               // blank line closes the header block
               rec.line_kind    = hhlp_pkg::KIND_END;
               rec.key_length   = 16'd0;
               rec.value_start  = nx_w[15:0];
               rec.value_length = 16'd0;
               rec.length_value = 32'd0;
               rec.final_record = 1'b1;
               headers_done_in  = 1'b1;
            end
            line_start_in   = ofs_next;
            phase_in        = hhlp_pkg::PHASE_KEY;
            colon_offset_in = '0;
            value_offset_in = '0;
            match_flags_in  = '1;
            prior_cr_in     = 1'b0;
            digit_acc_in    = '0;
            digits_on_in    = 1'b1;
         end else if (last_byte) begin
            // unterminated line loses its last byte
            rec_valid        = byte_offset_ff != line_start_ff;
            rec.final_record = 1'b1;
         end else begin
            case (phase_ff)
               hhlp_pkg::PHASE_KEY: begin
                  if (data_byte == hhlp_pkg::CHAR_COLON) begin
                     colon_offset_in = byte_offset_ff;
                     phase_in        = hhlp_pkg::PHASE_BLANK;
                  end else begin
                     match_flags_in = match_flags_ff & ~name_miss;
                  end
               end
               hhlp_pkg::PHASE_BLANK: begin
                  if (data_byte != hhlp_pkg::CHAR_SPACE && data_byte != hhlp_pkg::CHAR_TAB) begin
                     value_offset_in = byte_offset_ff;
                     phase_in        = hhlp_pkg::PHASE_VALUE;
                     if (is_digit) digit_acc_in = digit_next;
                     else          digits_on_in = 1'b0;
                  end
               end
               default: begin
                  if (digits_on_ff) begin
                     if (is_digit) digit_acc_in = digit_next;
                     else          digits_on_in = 1'b0;
                  end
               end
            endcase
            prior_cr_in = data_byte == hhlp_pkg::CHAR_CR;
         end

         // last byte of the buffer: back to the reset state
         if (last_byte) begin
            byte_offset_in  = '0;
            line_start_in   = '0;
            headers_done_in = 1'b0;
            phase_in        = hhlp_pkg::PHASE_KEY;
            colon_offset_in = '0;
            value_offset_in = '0;
            match_flags_in  = '1;
            prior_cr_in     = 1'b0;
            digit_acc_in    = '0;
            digits_on_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= hhlp_pkg::PHASE_KEY;
         byte_offset_ff  <= '0;
         line_start_ff   <= '0;
         colon_offset_ff <= '0;
         value_offset_ff <= '0;
         match_flags_ff  <= '1;
         prior_cr_ff     <= 1'b0;
         digit_acc_ff    <= '0;
         digits_on_ff    <= 1'b1;
         headers_done_ff <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         byte_offset_ff  <= byte_offset_in;
         line_start_ff   <= line_start_in;
         colon_offset_ff <= colon_offset_in;
         value_offset_ff <= value_offset_in;
         match_flags_ff  <= match_flags_in;
         prior_cr_ff     <= prior_cr_in;
         digit_acc_ff    <= digit_acc_in;
         digits_on_ff    <= digits_on_in;
         headers_done_ff <= headers_done_in;
      end
   end

endmodule

// File: sv/hhlp_rsp_skid.sv
// Result register plus one skid word; input side stalls only when the skid is full.
module hhlp_rsp_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              rec_valid,
   input  hhlp_pkg::rec_type rec,
   output logic              in_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hhlp_pkg::rec_type rsp_rec
);

   hhlp_pkg::rec_type out_ff, out_in;
   hhlp_pkg::rec_type skid_ff, skid_in;
   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   logic              out_free;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_stall  = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_rec   = out_ff;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         // no new word can arrive while the skid is full
         if (out_free) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (rec_valid) begin
         if (out_free) begin
            out_in       = rec;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = rec;
            skid_valid_in = 1'b1;
         end
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

// File: sv/http_header_line_parser.sv
// A line's record comes from its closing byte and is registered before it reaches rsp_.
// Throughput: one byte per cycle while req_stall is low, set by the registered parser state update.
// req_stall rises only when the result register and its skid word both hold records.
// Reset: synchronous, active high; parser returns to the start of a key, offsets zero,
// and any held records are dropped.
module http_header_line_parser #(
   parameter int OFFSET_BITS = hhlp_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // byte stream in
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // line records out
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_line_kind,
   output logic [15:0] rsp_key_start,
   output logic [15:0] rsp_key_length,
   output logic [15:0] rsp_value_start,
   output logic [15:0] rsp_value_length,
   output logic [31:0] rsp_length_value,
   output logic        rsp_final_record
);

   logic              byte_fire;
   logic              rec_valid;
   hhlp_pkg::rec_type rec;
   hhlp_pkg::rec_type rsp_rec;

   // a word is taken whenever the skid has room; no wait on an idle state
   assign byte_fire = req_valid && !req_stall;

   // parser: per-line offsets, name match flags and the decimal digit accumulator for every value
   hhlp_parse_core #(.OFFSET_BITS(OFFSET_BITS)) u_parse_core (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (byte_fire),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .rec_valid (rec_valid),
      .rec       (rec)
   );

   // result register with a one-word skid so a stalled consumer does not
   // halt the byte stream at once
   hhlp_rsp_skid u_rsp_skid (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (rec_valid),
      .rec       (rec),
      .in_stall  (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_rec   (rsp_rec)
   );

   assign rsp_line_kind    = rsp_rec.line_kind;
   assign rsp_key_start    = rsp_rec.key_start;
   assign rsp_key_length   = rsp_rec.key_length;
   assign rsp_value_start  = rsp_rec.value_start;
   assign rsp_value_length = rsp_rec.value_length;
   assign rsp_length_value = rsp_rec.length_value;
   assign rsp_final_record = rsp_rec.final_record;

endmodule
